@@ rtl/core/mmdr_pkg.sv @@
// ----------------------------------------------------------------------------
// mmdr_pkg
// Shared widths, codes, control word layout and the sequencer program for the
// multi-motor duty ramp controller.
// ----------------------------------------------------------------------------
package mmdr_pkg;

    localparam int NUM_MOTORS_DEF = 6;
    localparam int MAX_RES        = 6;
    localparam int CMD_W          = 2;
    localparam int SEL_W          = 3;
    localparam int DUR_W          = 16;
    localparam int ACC_W          = 8;
    localparam int DUTY_W         = 8;
    localparam int EMIT_CNT_W     = $clog2(MAX_RES + 1);
    localparam int DIV_CNT_W      = $clog2(DUR_W);

    localparam logic [DUTY_W-1:0] FULL_DUTY      = 8'd255;
    localparam logic [DUTY_W-1:0] RESET_MIN_DUTY = 8'd180;

    typedef enum logic [CMD_W-1:0] {
        CMD_RUN  = 2'd0,
        CMD_STOP = 2'd1,
        CMD_TICK = 2'd2
    } cmd_t;

    typedef logic [3:0] step_t;

    localparam step_t ST_IDLE      = 4'd0;
    localparam step_t ST_DISPATCH  = 4'd1;
    localparam step_t ST_CHECK     = 4'd2;
    localparam step_t ST_APPLY     = 4'd3;
    localparam step_t ST_EMIT_CMD  = 4'd4;
    localparam step_t ST_RETURN    = 4'd5;
    localparam step_t ST_TICK_INIT = 4'd6;
    localparam step_t ST_SCAN      = 4'd7;
    localparam step_t ST_ADVANCE   = 4'd8;
    localparam step_t ST_SETUP     = 4'd9;
    localparam step_t ST_DIVIDE    = 4'd10;
    localparam step_t ST_UPDATE    = 4'd11;
    localparam step_t ST_EMIT_TICK = 4'd12;
    localparam step_t ST_NEXT      = 4'd13;
    localparam step_t ST_DONE      = 4'd14;

    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_ACCEPT,
        ACT_APPLY,
        ACT_EMIT_CMD,
        ACT_TICK_INIT,
        ACT_ADVANCE,
        ACT_SETUP,
        ACT_DIV,
        ACT_UPDATE,
        ACT_EMIT_TICK,
        ACT_NEXT
    } act_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NO_FIRE,
        C_IS_TICK,
        C_BAD_CMD,
        C_OUT_WAIT,
        C_NOT_ACTIVE,
        C_SKIP_DIV,
        C_DIV_BUSY,
        C_MORE_MOTORS
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } uword_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

    // When the condition holds the sequencer jumps to target, otherwise it
    // moves on to the following step.
    function automatic uword_t ucode(step_t s);
        uword_t w;
        case (s)
            ST_IDLE:      w = '{ACT_ACCEPT,    C_NO_FIRE,     ST_IDLE};
            ST_DISPATCH:  w = '{ACT_NOP,       C_IS_TICK,     ST_TICK_INIT};
            ST_CHECK:     w = '{ACT_NOP,       C_BAD_CMD,     ST_IDLE};
            ST_APPLY:     w = '{ACT_APPLY,     C_ALWAYS,      ST_EMIT_CMD};
            ST_EMIT_CMD:  w = '{ACT_EMIT_CMD,  C_OUT_WAIT,    ST_EMIT_CMD};
            ST_RETURN:    w = '{ACT_NOP,       C_ALWAYS,      ST_IDLE};
            ST_TICK_INIT: w = '{ACT_TICK_INIT, C_ALWAYS,      ST_SCAN};
            ST_SCAN:      w = '{ACT_NOP,       C_NOT_ACTIVE,  ST_NEXT};
            ST_ADVANCE:   w = '{ACT_ADVANCE,   C_ALWAYS,      ST_SETUP};
            ST_SETUP:     w = '{ACT_SETUP,     C_SKIP_DIV,    ST_UPDATE};
            ST_DIVIDE:    w = '{ACT_DIV,       C_DIV_BUSY,    ST_DIVIDE};
            ST_UPDATE:    w = '{ACT_UPDATE,    C_ALWAYS,      ST_EMIT_TICK};
            ST_EMIT_TICK: w = '{ACT_EMIT_TICK, C_OUT_WAIT,    ST_EMIT_TICK};
            ST_NEXT:      w = '{ACT_NEXT,      C_MORE_MOTORS, ST_SCAN};
            ST_DONE:      w = '{ACT_NOP,       C_ALWAYS,      ST_IDLE};
            default:      w = '{ACT_NOP,       C_ALWAYS,      ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/mmdr_in_if.sv @@
// ----------------------------------------------------------------------------
// mmdr_in_if
// Command channel: run, stop and millisecond tick requests.
// ----------------------------------------------------------------------------
interface mmdr_in_if;
    import mmdr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [SEL_W-1:0]     motor_sel;
    logic                 open_dir;
    logic [DUR_W-1:0]     duration_ms;
    logic [ACC_W-1:0]     accel_div;

    modport source (
        output valid, cmd, motor_sel, open_dir, duration_ms, accel_div,
        input  ready
    );

    modport sink (
        input  valid, cmd, motor_sel, open_dir, duration_ms, accel_div,
        output ready
    );

endinterface

@@ rtl/core/mmdr_out_if.sv @@
// ----------------------------------------------------------------------------
// mmdr_out_if
// Status channel: one transfer per reported motor.
// ----------------------------------------------------------------------------
interface mmdr_out_if;
    import mmdr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [SEL_W-1:0]     motor_id;
    logic [DUTY_W-1:0]    duty;
    logic                 bridge_a;
    logic                 bridge_b;
    logic                 running;
    logic                 last;

    modport source (
        output valid, motor_id, duty, bridge_a, bridge_b, running, last,
        input  ready
    );

    modport sink (
        input  valid, motor_id, duty, bridge_a, bridge_b, running, last,
        output ready
    );

endinterface

@@ rtl/core/mmdr_divider.sv @@
// ----------------------------------------------------------------------------
// mmdr_divider
// Restoring divider, one quotient bit per step, for the ramp step count.
// ----------------------------------------------------------------------------
module mmdr_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mmdr_pkg::div_ctrl_t         ctrl,
    input  logic [mmdr_pkg::DUR_W-1:0]  dividend,
    input  logic [mmdr_pkg::ACC_W-1:0]  divisor,
    output logic [mmdr_pkg::DUR_W-1:0]  quotient,
    output logic                        last_step
);
    import mmdr_pkg::*;

    logic [DUR_W-1:0]     quo_reg, quo_next;
    logic [ACC_W-1:0]     rem_reg, rem_next;
    logic [ACC_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ACC_W:0]       partial;
    logic                 ge;

    always_comb
    begin
        partial  = {rem_reg, quo_reg[DUR_W-1]};
        ge       = partial >= {1'b0, dvs_reg};
        quo_next = {quo_reg[DUR_W-2:0], ge};
        rem_next = ge ? ACC_W'(partial - {1'b0, dvs_reg}) : partial[ACC_W-1:0];
        cnt_next = cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.load)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.step)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (ctrl.step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign last_step = (cnt_reg == DIV_CNT_W'(DUR_W - 1));

endmodule

@@ rtl/core/multi_motor_duty_ramp_top.sv @@
// ----------------------------------------------------------------------------
// multi_motor_duty_ramp_top
// PWM duty ramp and H-bridge control for a bank of DC motors.
// ----------------------------------------------------------------------------
// Usage:
//   req carries commands. A run loads direction, duration and ramp divisor for
//   one motor; a stop idles it; a tick advances every running motor by 1 ms.
//   rsp returns one transfer per reported motor with its duty, bridge pins and
//   running flag; last marks the final transfer caused by a command.
//   cfg_we / cfg_wdata write min_duty, to be done while the block is idle.
// Timing:
//   A sequencer steps through a microcode table, one control word a cycle,
//   and takes one command at a time. A run or stop passes the dispatch,
//   check, apply and emit steps before its result shows on rsp, and the
//   next command is taken after a return step. During a tick each idle
//   motor is only scanned, while each running motor is advanced, set up,
//   updated and reported; a ramping motor also passes the 16-step serial
//   divider between setup and update.
// Reset:
//   All motors idle, bridges low, duty 180, min_duty 180.
// Back-pressure:
//   Results sit in an output register; while rsp stalls the sequencer waits
//   at its emit step and req stays not ready.
// ----------------------------------------------------------------------------
module multi_motor_duty_ramp_top #(
    parameter int NUM_MOTORS = mmdr_pkg::NUM_MOTORS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    mmdr_in_if.sink                      req,
    mmdr_out_if.source                   rsp,
    input  logic                         cfg_we,
    input  logic [mmdr_pkg::DUTY_W-1:0]  cfg_wdata
);
    import mmdr_pkg::*;

    localparam int PTR_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

    // Sequencer
    step_t  step_reg, step_next;
    uword_t uw;
    logic   take;

    // Latched command
    logic [CMD_W-1:0] cmd_reg;
    logic [SEL_W-1:0] sel_reg;
    logic             dir_reg;
    logic [DUR_W-1:0] dur_reg;
    logic [ACC_W-1:0] acc_reg;

    // Per-motor state
    logic [NUM_MOTORS-1:0] active_reg;
    logic [1:0]            bridge_reg   [NUM_MOTORS];
    logic [DUTY_W-1:0]     duty_reg     [NUM_MOTORS];
    logic [ACC_W-1:0]      accel_reg    [NUM_MOTORS];
    logic [DUR_W-1:0]      duration_reg [NUM_MOTORS];
    logic [DUR_W-1:0]      elapsed_reg  [NUM_MOTORS];

    // Working registers
    logic [PTR_W-1:0]      ptr_reg;
    logic [EMIT_CNT_W-1:0] emit_cnt_reg;
    logic [DUTY_W-1:0]     min_duty_reg;
    logic                  done_reg;
    logic                  up_reg;
    logic                  down_reg;

    // Output register
    logic              out_valid_reg;
    logic [SEL_W-1:0]  out_id_reg;
    logic [DUTY_W-1:0] out_duty_reg;
    logic [1:0]        out_bridge_reg;
    logic              out_running_reg;
    logic              out_last_reg;

    logic              in_fire;
    logic              out_free;
    logic              emit_want;
    logic              emit_fire;
    logic              emit_last;
    logic              more_motors;
    logic [PTR_W-1:0]  sel_ptr;

    logic [DUR_W-1:0]  el_cur;
    logic [DUR_W-1:0]  dur_cur;
    logic [ACC_W-1:0]  acc_cur;
    logic [DUR_W:0]    el_inc;
    logic              adv_done;
    logic [DUR_W-1:0]  el_new;
    logic [DUR_W:0]    twice_el;
    logic              ramp_up;
    logic              ramp_down;
    logic [DUR_W-1:0]  dividend;
    logic              skip_div;
    logic [DUR_W:0]    duty_sum;
    logic [DUTY_W-1:0] duty_sat;

    div_ctrl_t         div_ctrl;
    logic [DUR_W-1:0]  quotient;
    logic              div_last;

    assign uw       = ucode(step_reg);
    assign sel_ptr  = PTR_W'(sel_reg);
    assign in_fire  = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        el_cur      = elapsed_reg[ptr_reg];
        dur_cur     = duration_reg[ptr_reg];
        acc_cur     = accel_reg[ptr_reg];

        el_inc      = {1'b0, el_cur} + 1'b1;
        adv_done    = el_inc >= {1'b0, dur_cur};
        el_new      = adv_done ? dur_cur : el_inc[DUR_W-1:0];

        // The midpoint test runs on the stored elapsed time, at the setup step after the advance.
        twice_el    = {el_cur, 1'b0};
        ramp_up     = twice_el < {1'b0, dur_cur};
        ramp_down   = twice_el > {1'b0, dur_cur};
        dividend    = ramp_up ? el_cur : dur_cur - el_cur;
        skip_div    = done_reg || (acc_cur == '0) || !(ramp_up || ramp_down);

        duty_sum    = {1'b0, quotient} + {{(DUR_W-DUTY_W+1){1'b0}}, min_duty_reg};
        duty_sat    = (duty_sum > {{(DUR_W-DUTY_W+1){1'b0}}, FULL_DUTY})
                      ? FULL_DUTY : duty_sum[DUTY_W-1:0];

        more_motors = (ptr_reg != PTR_W'(NUM_MOTORS - 1));

        case (uw.act)
            ACT_EMIT_CMD:  emit_want = 1'b1;
            ACT_EMIT_TICK: emit_want = (emit_cnt_reg < EMIT_CNT_W'(MAX_RES));
            default:       emit_want = 1'b0;
        endcase
        emit_fire = emit_want && out_free;

        // A tick result is the last one when the report limit is reached or
        // no motor above this one is still running.
        if (uw.act == ACT_EMIT_TICK)
        begin
            emit_last = (emit_cnt_reg == EMIT_CNT_W'(MAX_RES - 1))
                        || (((active_reg >> ptr_reg) >> 1) == '0);
        end
        else
        begin
            emit_last = 1'b1;
        end

        div_ctrl.load = (uw.act == ACT_SETUP);
        div_ctrl.step = (uw.act == ACT_DIV);
    end

    // Sequencer: next step from the jump condition of the current word.
    always_comb
    begin
        case (uw.cond)
            C_ALWAYS:      take = 1'b1;
            C_NO_FIRE:     take = !in_fire;
            C_IS_TICK:     take = (cmd_reg == CMD_TICK);
            C_BAD_CMD:     take = !(cmd_reg inside {CMD_RUN, CMD_STOP})
                                  || (int'(sel_reg) >= NUM_MOTORS);
            C_OUT_WAIT:    take = emit_want && !out_free;
            C_NOT_ACTIVE:  take = !active_reg[ptr_reg];
            C_SKIP_DIV:    take = skip_div;
            C_DIV_BUSY:    take = !div_last;
            C_MORE_MOTORS: take = more_motors;
            default:       take = 1'b0;
        endcase
        step_next = take ? uw.target : step_t'(step_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    mmdr_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (dividend),
        .divisor   (acc_cur),
        .quotient  (quotient),
        .last_step (div_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_duty_reg <= RESET_MIN_DUTY;
        end
        else if (cfg_we)
        begin
            min_duty_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= req.cmd;
            sel_reg <= req.motor_sel;
            dir_reg <= req.open_dir;
            dur_reg <= req.duration_ms;
            acc_reg <= req.accel_div;
        end
    end

    // Datapath actions selected by the control word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= '0;
            ptr_reg      <= '0;
            emit_cnt_reg <= '0;
            done_reg     <= 1'b0;
            up_reg       <= 1'b0;
            down_reg     <= 1'b0;
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                bridge_reg[i]   <= '0;
                duty_reg[i]     <= RESET_MIN_DUTY;
                accel_reg[i]    <= '0;
                duration_reg[i] <= '0;
                elapsed_reg[i]  <= '0;
            end
        end
        else
        begin
            case (uw.act)
                ACT_APPLY:
                begin
                    ptr_reg <= sel_ptr;
                    if (cmd_reg == CMD_RUN)
                    begin
                        accel_reg[sel_ptr]    <= acc_reg;
                        duration_reg[sel_ptr] <= dur_reg;
                        elapsed_reg[sel_ptr]  <= '0;
                        duty_reg[sel_ptr]     <= (acc_reg != '0) ? min_duty_reg : FULL_DUTY;
                        bridge_reg[sel_ptr]   <= dir_reg ? 2'b10 : 2'b01;
                        active_reg[sel_ptr]   <= 1'b1;
                    end
                    else
                    begin
                        bridge_reg[sel_ptr] <= '0;
                        active_reg[sel_ptr] <= 1'b0;
                    end
                end
                ACT_TICK_INIT:
                begin
                    ptr_reg      <= '0;
                    emit_cnt_reg <= '0;
                end
                ACT_ADVANCE:
                begin
                    elapsed_reg[ptr_reg] <= el_new;
                    done_reg             <= adv_done;
                end
                ACT_SETUP:
                begin
                    up_reg   <= ramp_up;
                    down_reg <= ramp_down;
                end
                ACT_UPDATE:
                begin
                    if (acc_cur != '0)
                    begin
                        if (done_reg)
                        begin
                            duty_reg[ptr_reg] <= min_duty_reg;
                        end
                        else if (up_reg && (duty_reg[ptr_reg] != FULL_DUTY))
                        begin
                            duty_reg[ptr_reg] <= duty_sat;
                        end
                        else if (down_reg)
                        begin
                            duty_reg[ptr_reg] <= duty_sat;
                        end
                    end
                    if (done_reg)
                    begin
                        bridge_reg[ptr_reg] <= '0;
                        active_reg[ptr_reg] <= 1'b0;
                    end
                end
                ACT_EMIT_TICK:
                begin
                    if (emit_fire)
                    begin
                        emit_cnt_reg <= emit_cnt_reg + 1'b1;
                    end
                end
                ACT_NEXT:
                begin
                    if (more_motors)
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_id_reg      <= SEL_W'(ptr_reg);
            out_duty_reg    <= duty_reg[ptr_reg];
            out_bridge_reg  <= bridge_reg[ptr_reg];
            out_running_reg <= active_reg[ptr_reg];
            out_last_reg    <= emit_last;
        end
    end

    assign req.ready    = (uw.act == ACT_ACCEPT);
    assign rsp.valid    = out_valid_reg;
    assign rsp.motor_id = out_id_reg;
    assign rsp.duty     = out_duty_reg;
    assign rsp.bridge_a = out_bridge_reg[0];
    assign rsp.bridge_b = out_bridge_reg[1];
    assign rsp.running  = out_running_reg;
    assign rsp.last     = out_last_reg;

endmodule
